@@ src/ultrasound_pixel_to_voxel_insert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the pixel-to-voxel insert block
// Clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ULTRASOUND_PIXEL_TO_VOXEL_INSERT_MACROS_SVH
`define ULTRASOUND_PIXEL_TO_VOXEL_INSERT_MACROS_SVH

// Consequent checked in the same cycle as the antecedent
`define PVI_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent
`define PVI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/pvi_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pvi_pkg
// Shared widths, codes and types of the pixel-to-voxel insert block.
// ----------------------------------------------------------------------------
package pvi_pkg;

    localparam int DIM_X_DEF     = 256;
    localparam int DIM_Y_DEF     = 256;
    localparam int DIM_Z_DEF     = 256;
    localparam int FRAC_BITS_DEF = 16;

    localparam int NUM_COEF = 9;
    localparam int COEF_W   = 32;
    localparam int CIDX_W   = 4;
    localparam int PIX_W    = 10;
    localparam int VAL_W    = 8;
    localparam int IDX_W    = 10;
    localparam int ADDR_W   = 24;
    localparam int PROD_W   = COEF_W + PIX_W + 1;
    localparam int ACC_W    = PROD_W + 2;

    localparam logic [CIDX_W-1:0] SLOT_ORIGIN = CIDX_W'(0);
    localparam logic [CIDX_W-1:0] SLOT_COL    = CIDX_W'(3);
    localparam logic [CIDX_W-1:0] SLOT_ROW    = CIDX_W'(6);

    typedef enum logic {
        CMD_LOAD  = 1'b0,
        CMD_PIXEL = 1'b1
    } cmd_t;

    typedef struct packed {
        logic prod_en;
        logic sum_en;
    } axis_en_t;

endpackage

@@ src/pvi_axis.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pvi_axis
// One axis of the pixel map: registered products, then sum, round half up,
// truncate toward zero and range check against the axis size.
// ----------------------------------------------------------------------------
module pvi_axis import pvi_pkg::*; #(
    parameter int DIM       = DIM_X_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                     clk,
    input  axis_en_t                 en,
    input  logic        [PIX_W-1:0]  pixel_x,
    input  logic        [PIX_W-1:0]  pixel_y,
    input  logic signed [COEF_W-1:0] origin,
    input  logic signed [COEF_W-1:0] col_step,
    input  logic signed [COEF_W-1:0] row_step,
    output logic        [IDX_W-1:0]  idx,
    output logic                     in_vol
);

    localparam logic signed [ACC_W-1:0] HALF      = ACC_W'(1) << (FRAC_BITS - 1);
    localparam logic signed [ACC_W-1:0] NEG_LIMIT = -(ACC_W'(1) << FRAC_BITS);
    localparam logic signed [ACC_W-1:0] DIM_LIMIT = ACC_W'(DIM);

    logic signed [PROD_W-1:0] col_prod_next;
    logic signed [PROD_W-1:0] row_prod_next;
    logic signed [PROD_W-1:0] col_prod_reg;
    logic signed [PROD_W-1:0] row_prod_reg;
    logic signed [COEF_W-1:0] origin_reg;
    logic signed [ACC_W-1:0]  acc;
    logic signed [ACC_W-1:0]  shifted;
    logic                     pos_inside;
    logic [IDX_W-1:0]         idx_next;
    logic                     inside_next;
    logic [IDX_W-1:0]         idx_reg;
    logic                     inside_reg;

    assign col_prod_next = $signed({1'b0, pixel_x}) * col_step;
    assign row_prod_next = $signed({1'b0, pixel_y}) * row_step;

    always_ff @(posedge clk)
    begin
        if (en.prod_en)
        begin
            col_prod_reg <= col_prod_next;
            row_prod_reg <= row_prod_next;
            origin_reg   <= origin;
        end
    end

    always_comb
    begin
        acc         = ACC_W'(origin_reg) + ACC_W'(col_prod_reg) + ACC_W'(row_prod_reg) + HALF;
        shifted     = acc >>> FRAC_BITS;
        pos_inside  = !acc[ACC_W-1] && (shifted < DIM_LIMIT);
        idx_next    = pos_inside ? shifted[IDX_W-1:0] : '0;
        inside_next = pos_inside || (acc[ACC_W-1] && (acc > NEG_LIMIT));
    end

    always_ff @(posedge clk)
    begin
        if (en.sum_en)
        begin
            idx_reg    <= idx_next;
            inside_reg <= inside_next;
        end
    end

    assign idx    = idx_reg;
    assign in_vol = inside_reg;

endmodule

@@ src/ultrasound_pixel_to_voxel_insert.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ultrasound_pixel_to_voxel_insert
// Nearest-neighbour insert of tracked pixels into a voxel volume: holds the
// nine map coefficients and turns each pixel into a voxel address and value.
// ----------------------------------------------------------------------------
//  channel  handshake                   payload
//  item     item_valid / item_ready     command, coef_index, coef_value,
//                                       pixel_x, pixel_y, intensity
//  result   result_valid / result_ready voxel_address, voxel_value
//
//  One item per cycle unless result_ready stalls the output; a pixel enters
//  the input register at the accepting edge and moves on through the product
//  and rounded-index registers to the address in the result register.
//  Coefficient loads retire as they leave the input register; they and
//  out-of-volume pixels give no result.
//  Each stage moves when empty or when the stage after it moves.
//  Reset clears the stage valid flags and all coefficients.
// ----------------------------------------------------------------------------
module ultrasound_pixel_to_voxel_insert import pvi_pkg::*; #(
    parameter int DIM_X     = DIM_X_DEF,
    parameter int DIM_Y     = DIM_Y_DEF,
    parameter int DIM_Z     = DIM_Z_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     item_valid,
    output logic                     item_ready,
    input  logic                     command,
    input  logic        [CIDX_W-1:0] coef_index,
    input  logic signed [COEF_W-1:0] coef_value,
    input  logic        [PIX_W-1:0]  pixel_x,
    input  logic        [PIX_W-1:0]  pixel_y,
    input  logic        [VAL_W-1:0]  intensity,
    output logic                     result_valid,
    input  logic                     result_ready,
    output logic        [ADDR_W-1:0] voxel_address,
    output logic        [VAL_W-1:0]  voxel_value
);

    localparam logic [ADDR_W-1:0] STRIDE_Y = ADDR_W'(DIM_X);
    localparam logic [ADDR_W-1:0] STRIDE_Z = ADDR_W'(DIM_X * DIM_Y);

    logic signed [COEF_W-1:0] coef_reg [NUM_COEF];

    logic                     s1_valid_reg;
    logic                     s1_cmd_reg;
    logic [CIDX_W-1:0]        s1_cidx_reg;
    logic signed [COEF_W-1:0] s1_cval_reg;
    logic [PIX_W-1:0]         s1_px_reg;
    logic [PIX_W-1:0]         s1_py_reg;
    logic [VAL_W-1:0]         s1_int_reg;

    logic                     s2_valid_reg;
    logic                     s2_valid_next;
    logic [VAL_W-1:0]         s2_int_reg;
    logic                     s3_valid_reg;
    logic                     s3_valid_next;
    logic [VAL_W-1:0]         s3_int_reg;
    logic                     result_valid_reg;
    logic                     result_valid_next;
    logic [ADDR_W-1:0]        addr_reg;
    logic [ADDR_W-1:0]        addr_next;
    logic [VAL_W-1:0]         val_reg;

    logic                     out_adv;
    logic                     s3_adv;
    logic                     s2_adv;
    logic                     s1_adv;
    logic                     coef_wr;
    axis_en_t                 axis_en;

    logic [IDX_W-1:0]         gx;
    logic [IDX_W-1:0]         gy;
    logic [IDX_W-1:0]         gz;
    logic                     in_x;
    logic                     in_y;
    logic                     in_z;

    assign out_adv    = !result_valid_reg || result_ready;
    assign s3_adv     = !s3_valid_reg || out_adv;
    assign s2_adv     = !s2_valid_reg || s3_adv;
    assign s1_adv     = !s1_valid_reg || s2_adv;
    assign item_ready = s1_adv;

    assign axis_en.prod_en = s2_adv;
    assign axis_en.sum_en  = s3_adv;

    assign coef_wr = s1_valid_reg && (s1_cmd_reg == CMD_LOAD) && s1_adv
                     && (s1_cidx_reg < CIDX_W'(NUM_COEF));

    // hold the item in the input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            s1_cmd_reg  <= command;
            s1_cidx_reg <= coef_index;
            s1_cval_reg <= coef_value;
            s1_px_reg   <= pixel_x;
            s1_py_reg   <= pixel_y;
            s1_int_reg  <= intensity;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_COEF; i++)
            begin
                coef_reg[i] <= '0;
            end
        end
        else if (coef_wr)
        begin
            coef_reg[s1_cidx_reg] <= s1_cval_reg;
        end
    end

    pvi_axis #(.DIM(DIM_X), .FRAC_BITS(FRAC_BITS)) u_axis_x (
        .clk      (clk),
        .en       (axis_en),
        .pixel_x  (s1_px_reg),
        .pixel_y  (s1_py_reg),
        .origin   (coef_reg[SLOT_ORIGIN]),
        .col_step (coef_reg[SLOT_COL]),
        .row_step (coef_reg[SLOT_ROW]),
        .idx      (gx),
        .in_vol   (in_x)
    );

    pvi_axis #(.DIM(DIM_Y), .FRAC_BITS(FRAC_BITS)) u_axis_y (
        .clk      (clk),
        .en       (axis_en),
        .pixel_x  (s1_px_reg),
        .pixel_y  (s1_py_reg),
        .origin   (coef_reg[SLOT_ORIGIN + CIDX_W'(1)]),
        .col_step (coef_reg[SLOT_COL + CIDX_W'(1)]),
        .row_step (coef_reg[SLOT_ROW + CIDX_W'(1)]),
        .idx      (gy),
        .in_vol   (in_y)
    );

    pvi_axis #(.DIM(DIM_Z), .FRAC_BITS(FRAC_BITS)) u_axis_z (
        .clk      (clk),
        .en       (axis_en),
        .pixel_x  (s1_px_reg),
        .pixel_y  (s1_py_reg),
        .origin   (coef_reg[SLOT_ORIGIN + CIDX_W'(2)]),
        .col_step (coef_reg[SLOT_COL + CIDX_W'(2)]),
        .row_step (coef_reg[SLOT_ROW + CIDX_W'(2)]),
        .idx      (gz),
        .in_vol   (in_z)
    );

    // drop loads after the input register, drop out-of-volume pixels before the result
    always_comb
    begin
        s2_valid_next     = s1_valid_reg && (s1_cmd_reg == CMD_PIXEL);
        s3_valid_next     = s2_valid_reg;
        result_valid_next = s3_valid_reg && in_x && in_y && in_z;
        addr_next         = ADDR_W'(gx) + ADDR_W'(gy) * STRIDE_Y + ADDR_W'(gz) * STRIDE_Z;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg     <= 1'b0;
            s3_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (s2_adv)
            begin
                s2_valid_reg <= s2_valid_next;
            end
            if (s3_adv)
            begin
                s3_valid_reg <= s3_valid_next;
            end
            if (out_adv)
            begin
                result_valid_reg <= result_valid_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_adv)
        begin
            s2_int_reg <= s1_int_reg;
        end
        if (s3_adv)
        begin
            s3_int_reg <= s2_int_reg;
        end
        if (out_adv)
        begin
            addr_reg <= addr_next;
            val_reg  <= s3_int_reg;
        end
    end

    assign result_valid  = result_valid_reg;
    assign voxel_address = addr_reg;
    assign voxel_value   = val_reg;

endmodule

@@ src/pvi_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pvi_checker
// Port-level checks on the pixel-to-voxel insert block, bound to the top level.
// ----------------------------------------------------------------------------
`include "ultrasound_pixel_to_voxel_insert_macros.svh"

module pvi_checker import pvi_pkg::*; #(
    parameter int DIM_X = DIM_X_DEF,
    parameter int DIM_Y = DIM_Y_DEF,
    parameter int DIM_Z = DIM_Z_DEF
) (
    input logic              clk,
    input logic              rst_n,
    input logic              item_ready,
    input logic              result_valid,
    input logic              result_ready,
    input logic [ADDR_W-1:0] voxel_address,
    input logic [VAL_W-1:0]  voxel_value
);

    localparam longint    VOL      = longint'(DIM_X) * longint'(DIM_Y) * longint'(DIM_Z);
    localparam bit        VOL_WIDE = VOL > (longint'(1) << ADDR_W);
    localparam logic [ADDR_W:0] VOL_LIM =
        VOL_WIDE ? ((ADDR_W + 1)'(1) << ADDR_W) : (ADDR_W + 1)'(VOL);

    `PVI_ASSERT_NEXT(a_result_held, result_valid && !result_ready, result_valid, "result dropped while stalled")
    `PVI_ASSERT_NEXT(a_payload_held, result_valid && !result_ready, $stable(voxel_address) && $stable(voxel_value), "result payload changed while stalled")
    `PVI_ASSERT_SAME(a_no_block, !result_valid || result_ready, item_ready, "item refused with free result register")
    `PVI_ASSERT_SAME(a_addr_range, result_valid, {1'b0, voxel_address} < VOL_LIM, "voxel address beyond the volume")

endmodule

bind ultrasound_pixel_to_voxel_insert pvi_checker #(
    .DIM_X (DIM_X),
    .DIM_Y (DIM_Y),
    .DIM_Z (DIM_Z)
) u_pvi_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .item_ready    (item_ready),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .voxel_address (voxel_address),
    .voxel_value   (voxel_value)
);
